### rtl/emprot_pkg.sv
// shared types and constants of the equal-power rotation block
package emprot_pkg;

	localparam int CH_NUM   = 8;
	localparam int CH_IDX_W = 3;
	localparam int CHS_W    = 4;
	localparam int POS_W    = 16;
	localparam int FRAC_W   = 15;
	localparam int SAMPLE_W = 24;
	localparam int GAIN_W   = 16;
	localparam int PROD_W   = 40;

	localparam logic [CHS_W-1:0] CHS_RESET = 4'd2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [GAIN_W-1:0]          gain_t;
	typedef logic [CH_IDX_W-1:0]        ch_idx_t;
	typedef logic [CHS_W-1:0]           chs_t;
	typedef logic [FRAC_W-1:0]          frac_t;

	typedef sample_t sample_arr_t [CH_NUM];

	typedef struct packed {
		gain_t gcos;
		gain_t gsin;
	} gain_pair_t;

	typedef struct packed {
		logic s3;
		logic s4;
	} mac_en_t;

endpackage

### rtl/emprot_gain_rom.sv
// quarter-wave gain table lookup, registered cos and sin gain pair
module emprot_gain_rom #(
	parameter int GAIN_TABLE_SIZE = 256
) (
	input  logic                 clk,
	input  logic                 en,
	input  emprot_pkg::frac_t    frac,
	output emprot_pkg::gain_pair_t gains_s2
);
	import emprot_pkg::*;

	localparam int TiW   = $clog2(GAIN_TABLE_SIZE + 1);
	localparam int ProdW = FRAC_W + TiW + 1;
	localparam longint unsigned HalfPiQ30 = 64'd1686629713;

	function automatic gain_t tab_entry(input int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          s;
		longint          g;
		x    = (HalfPiQ30 * longint'(k)) / GAIN_TABLE_SIZE;
		x2   = (x * x) >> 30;
		term = x;
		s    = longint'(x);
		term = ((term * x2) >> 30) / 6;
		s    = s - longint'(term);
		term = ((term * x2) >> 30) / 20;
		s    = s + longint'(term);
		term = ((term * x2) >> 30) / 42;
		s    = s - longint'(term);
		term = ((term * x2) >> 30) / 72;
		s    = s + longint'(term);
		term = ((term * x2) >> 30) / 110;
		s    = s - longint'(term);
		term = ((term * x2) >> 30) / 156;
		s    = s + longint'(term);
		term = ((term * x2) >> 30) / 210;
		s    = s - longint'(term);
		if (s < 0) begin
			s = 0;
		end
		g = (s + 64'sd16384) >>> 15;
		if (g > 64'sd32768) begin
			g = 64'sd32768;
		end
		return g[GAIN_W-1:0];
	endfunction

	gain_t gain_tab [GAIN_TABLE_SIZE+1];

	for (genvar k = 0; k <= GAIN_TABLE_SIZE; k++) begin : g_tab
		assign gain_tab[k] = tab_entry(k);
	end

	logic [ProdW-1:0] scaled;
	logic [TiW:0]     ti_full;
	logic [TiW-1:0]   ti;
	logic [TiW-1:0]   ti_cos;

	// table index with halves rounded up
	assign scaled  = ProdW'(frac) * ProdW'(GAIN_TABLE_SIZE) + ProdW'(16384);
	assign ti_full = scaled[ProdW-1:FRAC_W];

	always_comb begin
		if (ti_full > (TiW+1)'(GAIN_TABLE_SIZE)) begin
			ti = TiW'(GAIN_TABLE_SIZE);
		end else begin
			ti = ti_full[TiW-1:0];
		end
		ti_cos = TiW'(GAIN_TABLE_SIZE) - ti;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gains_s2.gsin <= gain_tab[ti];
			gains_s2.gcos <= gain_tab[ti_cos];
		end
	end

endmodule

### rtl/emprot_route.sv
// per output channel selection of the cos and sin source samples
module emprot_route (
	input  emprot_pkg::ch_idx_t     offset,
	input  emprot_pkg::chs_t        chs,
	input  emprot_pkg::sample_arr_t samples,
	output emprot_pkg::sample_arr_t sel_cos,
	output emprot_pkg::sample_arr_t sel_sin,
	output logic [emprot_pkg::CH_NUM-1:0] active
);
	import emprot_pkg::*;

	ch_idx_t j_cos [CH_NUM];
	ch_idx_t j_sin [CH_NUM];
	chs_t    chs_m1;

	assign chs_m1 = chs - chs_t'(1);

	for (genvar c = 0; c < CH_NUM; c++) begin : g_ch
		always_comb begin
			// source of the cos term is (c - offset) mod chs
			if (chs_t'(c) >= chs_t'(offset)) begin
				j_cos[c] = CH_IDX_W'(chs_t'(c) - chs_t'(offset));
			end else begin
				j_cos[c] = CH_IDX_W'(chs_t'(c) + chs - chs_t'(offset));
			end
			if (j_cos[c] == '0) begin
				j_sin[c] = chs_m1[CH_IDX_W-1:0];
			end else begin
				j_sin[c] = j_cos[c] - ch_idx_t'(1);
			end
			active[c]  = chs_t'(c) < chs;
			sel_cos[c] = samples[j_cos[c]];
			sel_sin[c] = samples[j_sin[c]];
		end
	end

endmodule

### rtl/emprot_mac.sv
// one output channel: two gain products, rounded sum and saturation
module emprot_mac (
	input  logic                   clk,
	input  emprot_pkg::mac_en_t    en,
	input  logic                   active_s2,
	input  emprot_pkg::sample_t    sel_cos_s2,
	input  emprot_pkg::sample_t    sel_sin_s2,
	input  emprot_pkg::gain_pair_t gains_s2,
	output emprot_pkg::sample_t    out_s4
);
	import emprot_pkg::*;

	localparam int SumW = PROD_W + 2;
	localparam int ShW  = SumW - FRAC_W;
	localparam logic signed [ShW-1:0] SatMax = ShW'(8388607);
	localparam logic signed [ShW-1:0] SatMin = -ShW'(8388608);

	logic signed [PROD_W:0]   pc_full;
	logic signed [PROD_W:0]   ps_full;
	logic signed [PROD_W-1:0] prod_cos_s3;
	logic signed [PROD_W-1:0] prod_sin_s3;
	logic                     active_s3;
	logic signed [SumW-1:0]   acc;
	logic signed [ShW-1:0]    shifted;
	sample_t                  sat;

	assign pc_full = sel_cos_s2 * $signed({1'b0, gains_s2.gcos});
	assign ps_full = sel_sin_s2 * $signed({1'b0, gains_s2.gsin});

	always_ff @(posedge clk) begin
		if (en.s3) begin
			prod_cos_s3 <= pc_full[PROD_W-1:0];
			prod_sin_s3 <= ps_full[PROD_W-1:0];
			active_s3   <= active_s2;
		end
	end

	always_comb begin
		acc     = SumW'(prod_cos_s3) + SumW'(prod_sin_s3) + SumW'(16384);
		shifted = acc[SumW-1:FRAC_W];
		if (shifted > SatMax) begin
			sat = SatMax[SAMPLE_W-1:0];
		end else if (shifted < SatMin) begin
			sat = SatMin[SAMPLE_W-1:0];
		end else begin
			sat = shifted[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			out_s4 <= active_s3 ? sat : '0;
		end
	end

endmodule

### rtl/multichannel_equal_power_rotate_top.sv
// equal-power circular rotation of one multichannel audio frame, top level
//
// Usage: one frame (a Q1.15 rotation position and eight Q1.23 samples) is
// offered on the frame channel and moves on a transfer when frame_valid is
// high and frame_stall is low. Each frame gives exactly one result on the
// result channel (eight saturated Q1.23 outputs, zero above the active
// channel count), taken when result_valid is high and result_stall is low.
// The channel count is written through cfg_wen/cfg_wdata; the user writes it
// only while idle, as the block itself does not enforce this. 0 acts as one
// channel and values above MAX_CHANNELS act as MAX_CHANNELS. result_valid
// rises after the frame transfer through four register stages: position
// scaling, gain table lookup with routing, the gain multiplies, then the
// rounded sum with saturation; one frame per cycle while result_stall is low.
// When the receiver stalls, the stages fill up one by one and frame_stall
// rises once the first stage is held; no frame is lost or repeated, and
// empty stages still close up behind a stalled result.
// Reset empties the pipeline and sets the channel count to 2.
module multichannel_equal_power_rotate_top #(
	parameter int MAX_CHANNELS    = 8,
	parameter int GAIN_TABLE_SIZE = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  emprot_pkg::chs_t          cfg_wdata,
	input  logic                      frame_valid,
	output logic                      frame_stall,
	input  logic signed [emprot_pkg::POS_W-1:0] position,
	input  emprot_pkg::sample_t       sample_0,
	input  emprot_pkg::sample_t       sample_1,
	input  emprot_pkg::sample_t       sample_2,
	input  emprot_pkg::sample_t       sample_3,
	input  emprot_pkg::sample_t       sample_4,
	input  emprot_pkg::sample_t       sample_5,
	input  emprot_pkg::sample_t       sample_6,
	input  emprot_pkg::sample_t       sample_7,
	output logic                      result_valid,
	input  logic                      result_stall,
	output emprot_pkg::sample_t       out_0,
	output emprot_pkg::sample_t       out_1,
	output emprot_pkg::sample_t       out_2,
	output emprot_pkg::sample_t       out_3,
	output emprot_pkg::sample_t       out_4,
	output emprot_pkg::sample_t       out_5,
	output emprot_pkg::sample_t       out_6,
	output emprot_pkg::sample_t       out_7
);
	import emprot_pkg::*;

	localparam int IdxW = CHS_W + FRAC_W;

	chs_t        chs_cfg_q;
	chs_t        chs_eff;
	logic [IdxW-1:0] idx;
	sample_arr_t samples_in;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic        ready_s1, ready_s2, ready_s3, ready_s4;
	chs_t        chs_s1;
	ch_idx_t     offset_s1;
	frac_t       frac_s1;
	sample_arr_t samples_s1;

	sample_arr_t sel_cos, sel_sin;
	logic [CH_NUM-1:0] active;
	sample_arr_t sel_cos_s2, sel_sin_s2;
	logic [CH_NUM-1:0] active_s2;
	gain_pair_t  gains_s2;
	mac_en_t     mac_en;
	sample_arr_t out_s4;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chs_cfg_q <= CHS_RESET;
		end else if (cfg_wen) begin
			chs_cfg_q <= cfg_wdata;
		end
	end

	// handshake chain
	assign ready_s4     = !valid_s4 || !result_stall;
	assign ready_s3     = !valid_s3 || ready_s4;
	assign ready_s2     = !valid_s2 || ready_s3;
	assign ready_s1     = !valid_s1 || ready_s2;
	assign frame_stall  = !ready_s1;
	assign result_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= frame_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: channel count clamp and position scaling
	always_comb begin
		if (chs_cfg_q == '0) begin
			chs_eff = chs_t'(1);
		end else if (chs_cfg_q > chs_t'(MAX_CHANNELS)) begin
			chs_eff = chs_t'(MAX_CHANNELS);
		end else begin
			chs_eff = chs_cfg_q;
		end
	end

	// channel count times the low 15 position bits; negative positions wrap
	assign idx = IdxW'(chs_eff) * IdxW'(position[FRAC_W-1:0]);

	assign samples_in[0] = sample_0;
	assign samples_in[1] = sample_1;
	assign samples_in[2] = sample_2;
	assign samples_in[3] = sample_3;
	assign samples_in[4] = sample_4;
	assign samples_in[5] = sample_5;
	assign samples_in[6] = sample_6;
	assign samples_in[7] = sample_7;

	always_ff @(posedge clk) begin
		if (ready_s1 && frame_valid) begin
			chs_s1     <= chs_eff;
			offset_s1  <= idx[FRAC_W +: CH_IDX_W];
			frac_s1    <= idx[FRAC_W-1:0];
			samples_s1 <= samples_in;
		end
	end

	// stage 2: gain lookup and routing
	emprot_gain_rom #(
		.GAIN_TABLE_SIZE(GAIN_TABLE_SIZE)
	) u_gain_rom (
		.clk     (clk),
		.en      (ready_s2 && valid_s1),
		.frac    (frac_s1),
		.gains_s2(gains_s2)
	);

	emprot_route u_route (
		.offset (offset_s1),
		.chs    (chs_s1),
		.samples(samples_s1),
		.sel_cos(sel_cos),
		.sel_sin(sel_sin),
		.active (active)
	);

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			sel_cos_s2 <= sel_cos;
			sel_sin_s2 <= sel_sin;
			active_s2  <= active;
		end
	end

	// stages 3 and 4: products, rounded sum and saturation
	assign mac_en.s3 = ready_s3 && valid_s2;
	assign mac_en.s4 = ready_s4 && valid_s3;

	for (genvar c = 0; c < CH_NUM; c++) begin : g_mac
		emprot_mac u_mac (
			.clk       (clk),
			.en        (mac_en),
			.active_s2 (active_s2[c]),
			.sel_cos_s2(sel_cos_s2[c]),
			.sel_sin_s2(sel_sin_s2[c]),
			.gains_s2  (gains_s2),
			.out_s4    (out_s4[c])
		);
	end

	assign out_0 = out_s4[0];
	assign out_1 = out_s4[1];
	assign out_2 = out_s4[2];
	assign out_3 = out_s4[3];
	assign out_4 = out_s4[4];
	assign out_5 = out_s4[5];
	assign out_6 = out_s4[6];
	assign out_7 = out_s4[7];

	a_stall_needs_full_s1: assert property (@(posedge clk) disable iff (!arst_n)
		frame_stall |-> valid_s1)
		else $error("frame stall with empty first stage");

	a_no_stall_passes: assert property (@(posedge clk) disable iff (!arst_n)
		!result_stall |-> !frame_stall)
		else $error("frame stalled while the receiver takes results");

	a_chs_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (chs_s1 != '0) && (chs_s1 <= chs_t'(MAX_CHANNELS)))
		else $error("channel count out of range in first stage");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (chs_t'(offset_s1) < chs_s1))
		else $error("channel offset not below channel count");

endmodule
